@@ hdl/seat_back_imbalance_monitor_core_assert.svh @@
// Assertion macros used by the seat/back imbalance monitor core.
`ifndef SEAT_BACK_IMBALANCE_MONITOR_CORE_ASSERT_SVH
`define SEAT_BACK_IMBALANCE_MONITOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBIM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBIM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sbim_pkg.sv @@
// Package with the constants, codes and types of the seat/back imbalance monitor.
package sbim_pkg;

   // Field widths.
   localparam int SAMPLE_BITS = 12;
   localparam int THRESH_BITS = 12;
   localparam int TIME_BITS   = 32;
   localparam int DUR_BITS    = 16;
   localparam int TALLY_BITS  = 16;
   localparam int SUM_BITS    = 32;
   localparam int SCORE_BITS  = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   // Derived widths.
   localparam int PRESS_BITS = SAMPLE_BITS - 1;
   localparam int CMP_BITS   = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int ACC_BITS   = ((TIME_BITS > SUM_BITS) ? TIME_BITS : SUM_BITS) + 1;

   // Scoring constants.
   localparam logic [SCORE_BITS-1:0] SCORE_MAX    = SCORE_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] BALANCE_LIM = SAMPLE_BITS'(50);

   // Reset values of the configuration registers.
   localparam logic [THRESH_BITS-1:0] LOAD_LEVEL_RST     = THRESH_BITS'(100);
   localparam logic [THRESH_BITS-1:0] IMB_THRESHOLD_RST  = THRESH_BITS'(50);
   localparam logic [DUR_BITS-1:0]    ALARM_DURATION_RST = DUR_BITS'(5000);

   // Saturation limits.
   localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;
   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOAD_LEVEL     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMB_THRESHOLD  = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALARM_DURATION = CSR_IDX_BITS'(2);

   // Transaction operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Result of scoring one sample.
   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic                  flag;
   } sbim_score_type;

endpackage

@@ hdl/sbim_score.sv @@
// Scoring and imbalance classification of one seat/back sample.
module sbim_score
   import sbim_pkg::*;
(
   input  logic [SAMPLE_BITS-1:0] seat_reading,
   input  logic [SAMPLE_BITS-1:0] back_reading,
   input  logic [THRESH_BITS-1:0] load_limit,
   input  logic [THRESH_BITS-1:0] diff_limit,
   output sbim_score_type         result
);

   logic [SAMPLE_BITS-1:0] diff;
   logic [SCORE_BITS-1:0]  balance;
   logic [SAMPLE_BITS:0]   press_sum;
   logic [PRESS_BITS-1:0]  press_raw;
   logic [SCORE_BITS-1:0]  pressure;
   logic [SCORE_BITS:0]    score_sum;
   logic                   seat_load;
   logic                   back_load;
   logic                   imbalance_flag;

   // Absolute difference of the two readings.
   assign diff = (seat_reading > back_reading) ? (seat_reading - back_reading)
                                               : (back_reading - seat_reading);

   // Balance term: 100 - 2*diff, floored at zero. Below the limit 2*diff fits the score width.
   assign balance = (diff < BALANCE_LIM) ? (SCORE_MAX - SCORE_BITS'({diff, 1'b0}))
                                         : '0;

   // Pressure term: quarter of the sum, capped at 100.
   assign press_sum = {1'b0, seat_reading} + {1'b0, back_reading};
   assign press_raw = press_sum[SAMPLE_BITS:2];
   assign pressure  = (press_raw > PRESS_BITS'(SCORE_MAX)) ? SCORE_MAX
                                                            : SCORE_BITS'(press_raw);

   // Truncated mean of the two terms.
   assign score_sum    = {1'b0, balance} + {1'b0, pressure};
   assign result.score = score_sum[SCORE_BITS:1];

   // Load detection and imbalance classification.
   assign seat_load = CMP_BITS'(seat_reading) > CMP_BITS'(load_limit);
   assign back_load = CMP_BITS'(back_reading) > CMP_BITS'(load_limit);

   always_comb begin
      if (seat_load != back_load) begin
         imbalance_flag = 1'b1;
      end else if (seat_load) begin
         imbalance_flag = CMP_BITS'(diff) > CMP_BITS'(diff_limit);
      end else begin
         imbalance_flag = 1'b0;
      end
   end

   assign result.flag = imbalance_flag;

endmodule

@@ hdl/seat_back_imbalance_monitor_core.sv @@
// Top level of the seat/back imbalance monitor: pipeline, state and configuration.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    req_op, req_seat_reading, req_back_reading
//   rsp      out        rsp_valid / rsp_stall    score, flag, alarm, episode count, total ms
//   csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
// One transaction is accepted per cycle while req_stall is low; each gives one result
// through the input register, then the scoring and state update into the result register.
// The rate is set by the single state update stage, which handles one item a cycle unless stalled.
// Reset is synchronous and active high; the block is ready on the cycle after it.
// A stalled result holds the result register and, once the input register is also
// full, raises req_stall; csr_ready is always high.
module seat_back_imbalance_monitor_core
   import sbim_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input transactions
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [SAMPLE_BITS-1:0]   req_seat_reading,
   input  logic [SAMPLE_BITS-1:0]   req_back_reading,
   // Result transactions
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SCORE_BITS-1:0]    rsp_posture_score,
   output logic                     rsp_imbalance_now,
   output logic                     rsp_alarm_on,
   output logic [TALLY_BITS-1:0]    rsp_episode_count,
   output logic [SUM_BITS-1:0]      rsp_imbalance_total_ms,
   // Configuration writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

`include "seat_back_imbalance_monitor_core_assert.svh"

   // Configuration registers.
   logic [THRESH_BITS-1:0] load_level_ff;
   logic [THRESH_BITS-1:0] imb_threshold_ff;
   logic [DUR_BITS-1:0]    alarm_duration_ff;

   // Input register.
   logic                   stg_valid_ff;
   logic                   stg_op_ff;
   logic [SAMPLE_BITS-1:0] stg_seat_ff;
   logic [SAMPLE_BITS-1:0] stg_back_ff;

   // Monitor state.
   logic [TIME_BITS-1:0]  ms_clock_ff,        ms_clock_in;
   logic                  in_episode_ff,      in_episode_in;
   logic [TIME_BITS-1:0]  episode_start_ff,   episode_start_in;
   logic [TALLY_BITS-1:0] episode_tally_ff,   episode_tally_in;
   logic [SUM_BITS-1:0]   imbalance_sum_ff,   imbalance_sum_in;
   logic                  alarm_active_ff,    alarm_active_in;
   logic [DUR_BITS-1:0]   alarm_remaining_ff, alarm_remaining_in;
   logic [SCORE_BITS-1:0] last_score_ff,      last_score_in;
   logic                  last_flag_ff,       last_flag_in;

   // Result register.
   logic rsp_valid_ff;

   logic                  advance;
   sbim_score_type        scored;
   logic [TIME_BITS-1:0]  episode_len;
   logic [ACC_BITS-1:0]   sum_total;

   // The input register moves on when the result register is empty or being taken.
   assign advance   = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stg_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_level_ff     <= LOAD_LEVEL_RST;
         imb_threshold_ff  <= IMB_THRESHOLD_RST;
         alarm_duration_ff <= ALARM_DURATION_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOAD_LEVEL:     load_level_ff     <= THRESH_BITS'(csr_wdata);
            CSR_IMB_THRESHOLD:  imb_threshold_ff  <= THRESH_BITS'(csr_wdata);
            CSR_ALARM_DURATION: alarm_duration_ff <= DUR_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Input register capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stg_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stg_op_ff   <= req_op;
         stg_seat_ff <= req_seat_reading;
         stg_back_ff <= req_back_reading;
      end
   end

   // Sample scoring.
   sbim_score u_score (
      .seat_reading (stg_seat_ff),
      .back_reading (stg_back_ff),
      .load_limit   (load_level_ff),
      .diff_limit   (imb_threshold_ff),
      .result       (scored)
   );

   // Episode length wraps with the clock; the closed total saturates.
   assign episode_len = ms_clock_ff - episode_start_ff;
   assign sum_total   = ACC_BITS'(imbalance_sum_ff) + ACC_BITS'(episode_len);

   // Next state for a tick or a sample.
   always_comb begin
      ms_clock_in        = ms_clock_ff;
      in_episode_in      = in_episode_ff;
      episode_start_in   = episode_start_ff;
      episode_tally_in   = episode_tally_ff;
      imbalance_sum_in   = imbalance_sum_ff;
      alarm_active_in    = alarm_active_ff;
      alarm_remaining_in = alarm_remaining_ff;
      last_score_in      = last_score_ff;
      last_flag_in       = last_flag_ff;

      if (stg_op_ff == OP_SAMPLE) begin
         last_score_in = scored.score;
         last_flag_in  = scored.flag;

         // A rising flag opens an episode, a falling flag closes it.
         if (scored.flag && !in_episode_ff) begin
            in_episode_in    = 1'b1;
            episode_start_in = ms_clock_ff;
            if (episode_tally_ff != TALLY_MAX) begin
               episode_tally_in = episode_tally_ff + TALLY_BITS'(1);
            end
         end else if (!scored.flag && in_episode_ff) begin
            in_episode_in = 1'b0;
            if (sum_total[ACC_BITS-1:SUM_BITS] != '0) begin
               imbalance_sum_in = SUM_MAX;
            end else begin
               imbalance_sum_in = sum_total[SUM_BITS-1:0];
            end
         end

         // A flagged sample starts the alarm only while it is off.
         if (scored.flag && !alarm_active_ff) begin
            alarm_active_in    = 1'b1;
            alarm_remaining_in = alarm_duration_ff;
         end
      end else begin
         ms_clock_in = ms_clock_ff + TIME_BITS'(1);

         // Countdown; the alarm clears on the tick that reaches zero.
         if (alarm_active_ff) begin
            if (alarm_remaining_ff <= DUR_BITS'(1)) begin
               alarm_remaining_in = '0;
               alarm_active_in    = 1'b0;
            end else begin
               alarm_remaining_in = alarm_remaining_ff - DUR_BITS'(1);
            end
         end
      end
   end

   // State update on each advancing transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_clock_ff        <= '0;
         in_episode_ff      <= 1'b0;
         episode_start_ff   <= '0;
         episode_tally_ff   <= '0;
         imbalance_sum_ff   <= '0;
         alarm_active_ff    <= 1'b0;
         alarm_remaining_ff <= '0;
         last_score_ff      <= '0;
         last_flag_ff       <= 1'b0;
      end else if (advance) begin
         ms_clock_ff        <= ms_clock_in;
         in_episode_ff      <= in_episode_in;
         episode_start_ff   <= episode_start_in;
         episode_tally_ff   <= episode_tally_in;
         imbalance_sum_ff   <= imbalance_sum_in;
         alarm_active_ff    <= alarm_active_in;
         alarm_remaining_ff <= alarm_remaining_in;
         last_score_ff      <= last_score_in;
         last_flag_ff       <= last_flag_in;
      end
   end

   // Result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload is the state after the update.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_posture_score      <= last_score_in;
         rsp_imbalance_now      <= last_flag_in;
         rsp_alarm_on           <= alarm_active_in;
         rsp_episode_count      <= episode_tally_in;
         rsp_imbalance_total_ms <= imbalance_sum_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An idle alarm always has an empty countdown.
   `SBIM_ASSERT_SAME(a_alarm_idle_clear, clock, reset, !alarm_active_ff,
      alarm_remaining_ff == '0, "alarm off with a live countdown")

   // The episode flag follows the latest sample classification.
   `SBIM_ASSERT_SAME(a_episode_tracks_flag, clock, reset, 1'b1,
      in_episode_ff == last_flag_ff, "episode state differs from last flag")

   // An advancing transaction always lands in the result register.
   `SBIM_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance,
      rsp_valid_ff, "advanced transaction lost")

   // The episode count never goes down.
   `SBIM_ASSERT_SAME(a_tally_monotonic, clock, reset, !$past(reset),
      episode_tally_ff >= $past(episode_tally_ff), "episode count decreased")

   // Delivered scores stay within range.
   `SBIM_ASSERT_SAME(a_score_range, clock, reset, rsp_valid_ff,
      rsp_posture_score <= SCORE_MAX, "posture score above maximum")

endmodule
